### hdl/sfcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_pkg
// Shared types and constants of the sync-framed command decoder.
// ----------------------------------------------------------------------------
package sfcd_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hA5;
    localparam logic [7:0] SYNC_SECOND = 8'h5A;

    // Frame bytes 2..14 live in the byte chain while byte 15 arrives.
    localparam int CHAIN_LEN = 13;

    localparam logic [7:0] TYPE_TX   = 8'd1;
    localparam logic [7:0] TYPE_PING = 8'd2;
    localparam logic [7:0] TYPE_RATE = 8'd3;

    localparam logic [3:0]  DLC_MAX  = 4'd8;
    localparam logic [31:0] RATE_MIN = 32'd125000;
    localparam logic [31:0] RATE_MAX = 32'd1000000;

    localparam logic [1:0] ACT_TX     = 2'd0;
    localparam logic [1:0] ACT_PONG   = 2'd1;
    localparam logic [1:0] ACT_RATE   = 2'd2;
    localparam logic [1:0] ACT_STATUS = 2'd3;

    localparam logic [1:0] ST_BAD_TYPE = 2'd0;
    localparam logic [1:0] ST_BAD_DLC  = 2'd1;
    localparam logic [1:0] ST_BAD_RATE = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  report_code;
        logic [7:0]  tag;
        logic [10:0] can_id;
        logic [3:0]  dlc;
        logic [63:0] payload;
        logic [31:0] argument;
    } result_t;

    // Framer to decoder control.
    typedef struct packed {
        logic shift;  // a byte is accepted this cycle
        logic done;   // the accepted byte completes a frame
    } frame_ctl_t;

endpackage

### hdl/sfcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_byte_if / sfcd_result_if
// Valid/ready channels for incoming bytes and decoded results.
// ----------------------------------------------------------------------------
interface sfcd_byte_if;
    import sfcd_pkg::*;
    logic  valid;
    logic  ready;
    byte_t byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface sfcd_result_if;
    import sfcd_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  report_code;
    logic [7:0]  tag;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [31:0] argument;
    modport source (output valid, output action, output report_code, output tag,
                    output can_id, output dlc, output payload, output argument,
                    input ready);
    modport sink   (input valid, input action, input report_code, input tag,
                    input can_id, input dlc, input payload, input argument,
                    output ready);
endinterface

### hdl/sfcd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_cell
// One byte stage of the frame chain; loads its input byte on each shift.
// ----------------------------------------------------------------------------
module sfcd_cell (
    input  logic          clk,
    input  logic          shift,
    input  sfcd_pkg::byte_t d,
    output sfcd_pkg::byte_t q
);
    import sfcd_pkg::*;

    byte_t data_reg;
    byte_t data_next;

    assign data_next = shift ? d : data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### hdl/sfcd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_framer
// Sync hunt and frame position counter.
// ----------------------------------------------------------------------------
module sfcd_framer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  sfcd_pkg::byte_t      byte_in,
    output sfcd_pkg::frame_ctl_t ctl
);
    import sfcd_pkg::*;

    localparam logic [3:0] POS_HUNT  = 4'd0;
    localparam logic [3:0] POS_SYNC1 = 4'd1;
    localparam logic [3:0] POS_BODY  = 4'd2;
    localparam logic [3:0] POS_LAST  = 4'd15;

    logic [3:0] pos_reg;
    logic [3:0] pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            priority if (pos_reg == POS_HUNT)
            begin
                if (byte_in == SYNC_FIRST)
                    pos_next = POS_SYNC1;
            end
            else if (pos_reg == POS_SYNC1)
            begin
                if (byte_in == SYNC_SECOND)
                    pos_next = POS_BODY;
                else if (byte_in != SYNC_FIRST)
                    pos_next = POS_HUNT;
            end
            else if (pos_reg == POS_LAST)
                pos_next = POS_HUNT;
            else
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= POS_HUNT;
        else
            pos_reg <= pos_next;
    end

    assign ctl.shift = accept;
    assign ctl.done  = accept && (pos_reg == POS_LAST);

    // After the first sync byte the hunt can only restart, hold or advance.
    a_sync1_next: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos_reg == POS_SYNC1) |=>
            (pos_reg == POS_HUNT || pos_reg == POS_SYNC1 || pos_reg == POS_BODY))
        else $error("framer left the first sync state illegally");

    // A completed frame always sends the counter back to hunting.
    a_done_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> (pos_reg == POS_HUNT))
        else $error("framer did not return to hunt after a frame");

endmodule

### hdl/sfcd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfcd_decoder
// Decodes a completed frame by its type byte into the result register.
// ----------------------------------------------------------------------------
module sfcd_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfcd_pkg::frame_ctl_t ctl,
    input  sfcd_pkg::byte_t      chain [sfcd_pkg::CHAIN_LEN],
    input  sfcd_pkg::byte_t      byte_in,
    sfcd_result_if.source        rsp
);
    import sfcd_pkg::*;

    // Frame byte k (2..14) sits in chain[14 - k]; byte 15 is the incoming one.
    byte_t   fb [2:15];
    result_t res_next;
    result_t res_reg;
    logic    valid_reg;
    logic    valid_next;
    logic [63:0] data;
    logic [31:0] rate;
    logic [3:0]  dlc_raw;

    always_comb
    begin
        for (int k = 2; k < 15; k++)
            fb[k] = chain[14 - k];
        fb[15] = byte_in;
    end

    assign data    = {fb[15], fb[14], fb[13], fb[12], fb[11], fb[10], fb[9], fb[8]};
    assign rate    = {fb[11], fb[10], fb[9], fb[8]};
    assign dlc_raw = fb[6][3:0];

    always_comb
    begin
        res_next = '0;
        unique case (fb[2])
            TYPE_TX:
            begin
                if (dlc_raw > DLC_MAX)
                begin
                    res_next.action      = ACT_STATUS;
                    res_next.report_code = ST_BAD_DLC;
                    res_next.argument    = {28'd0, dlc_raw};
                end
                else
                begin
                    res_next.action  = ACT_TX;
                    res_next.can_id  = {fb[5][2:0], fb[4]};
                    res_next.dlc     = dlc_raw;
                    res_next.payload = data;
                end
            end
            TYPE_PING:
            begin
                res_next.action  = ACT_PONG;
                res_next.tag     = fb[3];
                res_next.payload = data;
            end
            TYPE_RATE:
            begin
                res_next.argument = rate;
                if (rate < RATE_MIN || rate > RATE_MAX)
                begin
                    res_next.action      = ACT_STATUS;
                    res_next.report_code = ST_BAD_RATE;
                end
                else
                    res_next.action = ACT_RATE;
            end
            default:
            begin
                res_next.action      = ACT_STATUS;
                res_next.report_code = ST_BAD_TYPE;
                res_next.argument    = {24'd0, fb[2]};
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.done)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
            res_reg <= res_next;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.action      = res_reg.action;
    assign rsp.report_code = res_reg.report_code;
    assign rsp.tag         = res_reg.tag;
    assign rsp.can_id      = res_reg.can_id;
    assign rsp.dlc         = res_reg.dlc;
    assign rsp.payload     = res_reg.payload;
    assign rsp.argument    = res_reg.argument;

    // Every completed frame shows up as a valid result on the next cycle.
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> valid_reg)
        else $error("completed frame produced no result");

    // A transmit request never carries a DLC above eight.
    a_tx_dlc: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.action == ACT_TX) |-> (res_reg.dlc <= DLC_MAX))
        else $error("transmit request with an oversized DLC");

endmodule

### hdl/sync_framed_command_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_command_decoder_core
// Hunts the A5 5A sync pair in a byte stream, gathers 16-byte frames and
// decodes each into a transmit, pong, bitrate or status result.
// ----------------------------------------------------------------------------
//
//   Channel  Role    Payload                                    Per request
//   cmd      sink    byte_in                                    one raw byte
//   rsp      source  action, report_code, tag, can_id, dlc,     one decoded
//                    payload, argument                          frame
//
// One byte is taken every cycle while cmd.ready is high; the byte that
// completes a frame yields a result in the output register in the next
// cycle, and the next byte may be taken in that same cycle. The 13-cell
// byte chain shifts once per accepted byte. cmd.ready drops only while a
// result is held unclaimed in the output register and rsp.ready is low.
// Reset returns the framer to the sync hunt and empties the output
// register; the byte chain holds no reset.
// ----------------------------------------------------------------------------
module sync_framed_command_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    sfcd_byte_if.sink     cmd,
    sfcd_result_if.source rsp
);
    import sfcd_pkg::*;

    logic       accept;
    frame_ctl_t ctl;
    byte_t      chain [CHAIN_LEN];

    // A new request is taken whenever the result slot is free or drains now.
    assign cmd.ready = !rsp.valid || rsp.ready;
    assign accept    = cmd.valid && cmd.ready;

    sfcd_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .byte_in (cmd.byte_in),
        .ctl     (ctl)
    );

    // The chain shifts on every accepted byte, so when byte 15 of a frame
    // arrives the cells hold bytes 14 down to 2 in order.
    for (genvar i = 0; i < CHAIN_LEN; i++)
    begin : g_chain
        if (i == 0)
        begin : g_head
            sfcd_cell u_cell (
                .clk   (clk),
                .shift (ctl.shift),
                .d     (cmd.byte_in),
                .q     (chain[i])
            );
        end
        else
        begin : g_body
            sfcd_cell u_cell (
                .clk   (clk),
                .shift (ctl.shift),
                .d     (chain[i-1]),
                .q     (chain[i])
            );
        end
    end

    sfcd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .chain   (chain),
        .byte_in (cmd.byte_in),
        .rsp     (rsp)
    );

endmodule
